### rtl/hst_pkg.sv
// Package for the heard station table: item kinds, result status codes, engine states,
// the request struct carried from the front end to the table engine and the result struct.
// No dependencies.
`default_nettype none
package hst_pkg;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_UPDATED = 3'd1,
    ST_INSERTED = 3'd2,
    ST_EVICTED = 3'd3,
    ST_CLEARED = 3'd4,
    ST_READ    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_WAIT,
    ENG_LOOK,
    ENG_WRITE,
    ENG_REPLY
  } eng_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [55:0] src;
    logic [55:0] dst;
    logic        beacon;
    logic [31:0] now;
    logic [5:0]  sel;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot;
    logic        entry_valid;
    logic [55:0] station_address;
    logic [55:0] last_dest;
    logic [31:0] last_heard;
    logic [31:0] beacon_time;
    logic        beacon_seen;
    logic [31:0] heard_count;
    logic [6:0]  occupancy;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/heard_station_table.sv
// Heard station table top level: APB register, request queue front end,
// table engine. Depends on hst_pkg, hst_front, hst_engine.
// A record item scans the slot memory (one slot read per cycle) and then
// updates a slot; a read item reads one slot; clear and ignored items go
// straight to the reply. A new item is taken only once the last one is done.
// Reset clears valid bits, occupancy and queues and sets active_limit to 64.
`default_nettype none
module heard_station_table import hst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind_i,
  input  wire logic [55:0] source_address_i,
  input  wire logic        source_valid_i,
  input  wire logic [55:0] dest_address_i,
  input  wire logic        is_ui_frame_i,
  input  wire logic        has_info_i,
  input  wire logic [31:0] now_seconds_i,
  input  wire logic [5:0]  slot_select_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       status_o,
  output logic [5:0]       slot_o,
  output logic             entry_valid_o,
  output logic [55:0]      station_address_o,
  output logic [55:0]      last_dest_o,
  output logic [31:0]      last_heard_o,
  output logic [31:0]      beacon_time_o,
  output logic             beacon_seen_o,
  output logic [31:0]      heard_count_o,
  output logic [6:0]       occupancy_o
);

  localparam logic [1:0] ADDR_LIMIT = 2'd0;

  logic [6:0] limit_q;
  logic       req_valid, req_take, rsp_valid;
  req_t       req;
  rsp_t       rsp;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LIMIT) ? {25'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 7'd64;
    else if (psel && penable && pwrite && paddr == ADDR_LIMIT) limit_q <= pwdata[6:0];
  end

  hst_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .kind_i, .source_address_i,
    .source_valid_i, .dest_address_i, .is_ui_frame_i, .has_info_i, .now_seconds_i,
    .slot_select_i, .req_valid_o(req_valid), .req_take_i(req_take), .req_o(req)
  );

  hst_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk_i, .rst_ni, .limit_i(limit_q), .req_valid_i(req_valid),
    .req_take_o(req_take), .req_i(req), .rsp_valid_o(rsp_valid),
    .rsp_take_i(pop), .rsp_o(rsp)
  );

  assign empty             = ~rsp_valid;
  assign status_o          = rsp.status;
  assign slot_o            = rsp.slot;
  assign entry_valid_o     = rsp.entry_valid;
  assign station_address_o = rsp.station_address;
  assign last_dest_o       = rsp.last_dest;
  assign last_heard_o      = rsp.last_heard;
  assign beacon_time_o     = rsp.beacon_time;
  assign beacon_seen_o     = rsp.beacon_seen;
  assign heard_count_o     = rsp.heard_count;
  assign occupancy_o       = rsp.occupancy;

endmodule
`default_nettype wire

### rtl/hst_front.sv
// Front end of the heard station table: takes input items, turns records
// with an invalid source into no-op items and queues requests (two deep).
// Depends on hst_pkg.
`default_nettype none
module hst_front import hst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [55:0] source_address_i,
  input  wire logic        source_valid_i,
  input  wire logic [55:0] dest_address_i,
  input  wire logic        is_ui_frame_i,
  input  wire logic        has_info_i,
  input  wire logic [31:0] now_seconds_i,
  input  wire logic [5:0]  slot_select_i,
  output logic             req_valid_o,
  input  wire logic        req_take_i,
  output req_t             req_o
);

  req_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  req_t       cls;
  logic       do_push, do_pop;

  always_comb begin
    cls.kind   = kind_e'(kind_i);
    // An invalid source is an item that changes nothing.
    if (kind_i == KIND_RECORD && !source_valid_i) cls.kind = KIND_NONE;
    cls.src    = source_address_i;
    cls.dst    = dest_address_i;
    cls.beacon = is_ui_frame_i & has_info_i;
    cls.now    = now_seconds_i;
    cls.sel    = slot_select_i;
  end

  assign full_o      = cnt_q[1];
  assign req_valid_o = cnt_q != 2'd0;
  assign req_o       = buf_q[rd_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = req_take_i & req_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("request queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> full_o)
    else $error("queue left full state without a pop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop && cnt_q == 2'd0) |=> req_valid_o)
    else $error("pushed request not visible");

endmodule
`default_nettype wire

### rtl/hst_engine.sv
// Table engine of the heard station table: for a record it scans the slots
// one a cycle for a match, a free slot and the oldest entry, then updates
// one slot; a read reads one slot, a clear empties the table. Depends on hst_pkg.
`default_nettype none
module hst_engine import hst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [6:0] limit_i,
  input  wire logic       req_valid_i,
  output logic            req_take_o,
  input  wire req_t       req_i,
  output logic            rsp_valid_o,
  input  wire logic       rsp_take_i,
  output rsp_t            rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic [55:0] station;
    logic [55:0] dest;
    logic [31:0] heard;
    logic [31:0] btime;
    logic        bflag;
    logic [31:0] count;
  } ent_t;

  ent_t               mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  ent_t               rd_q;
  logic [CW-1:0]      used_q, used_d;
  eng_state_e         state_q, state_d;
  req_t               cur_q;
  logic [AW-1:0]      idx_q;
  logic               found_q, free_q, old_q;
  logic [AW-1:0]      hit_q, fslot_q, oslot_q, tgt_q;
  logic [31:0]        otime_q;
  logic               scan_v_q;
  logic [AW-1:0]      scan_i_q;
  logic               rvalid_q;
  rsp_t               rsp_q, rsp_d;
  logic               evict_q;
  logic [CW-1:0]      lim;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      pick;
  logic               rd_en, wr_en;
  ent_t               wr_data;
  logic               insert, evict;
  status_e            st;

  always_comb begin
    lim = (limit_i == 7'd0) ? CW'(1) :
          (32'(limit_i) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(limit_i);
  end

  assign req_take_o  = (state_q == ENG_IDLE) && req_valid_i;
  assign rsp_valid_o = rvalid_q;
  assign rsp_o       = rsp_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ENG_IDLE: if (req_valid_i) begin
        unique case (req_i.kind)
          KIND_RECORD: state_d = ENG_SCAN;
          KIND_READ:   state_d = ENG_WAIT;
          default:     state_d = ENG_REPLY;
        endcase
      end
      ENG_SCAN:  if (idx_q == LAST) state_d = ENG_WAIT;
      ENG_WAIT:  state_d = ENG_LOOK;
      ENG_LOOK:  state_d = (cur_q.kind == KIND_READ) ? ENG_REPLY : ENG_WRITE;
      ENG_WRITE: state_d = ENG_REPLY;
      ENG_REPLY: if (!rvalid_q || rsp_take_i) state_d = ENG_IDLE;
      default:   state_d = ENG_IDLE;
    endcase
  end

  // The scan flags are final once the last slot was compared in WAIT.
  always_comb begin
    insert = ~found_q;
    evict  = insert && (used_q >= lim);
    pick   = found_q ? hit_q : (evict ? oslot_q : fslot_q);
  end

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    if (state_q == ENG_SCAN) rd_en = 1'b1;
    if (state_q == ENG_LOOK) begin
      rd_en = 1'b1;
      rd_addr = (cur_q.kind == KIND_READ) ? AW'(cur_q.sel) : pick;
    end
  end

  always_comb begin
    st = found_q ? ST_UPDATED : evict_q ? ST_EVICTED : ST_INSERTED;
    wr_en = (state_q == ENG_WRITE) && (found_q || (evict_q ? old_q : free_q));
    wr_data = rd_q;
    wr_data.heard = cur_q.now;
    wr_data.dest  = cur_q.dst;
    if (found_q) begin
      if (rd_q.count != 32'hFFFF_FFFF) wr_data.count = rd_q.count + 32'd1;
      if (cur_q.beacon) begin
        wr_data.btime = cur_q.now;
        wr_data.bflag = 1'b1;
      end
    end else begin
      wr_data.station = cur_q.src;
      wr_data.count   = 32'd1;
      wr_data.bflag   = cur_q.beacon;
      wr_data.btime   = cur_q.beacon ? cur_q.now : 32'd0;
    end
    used_d = used_q;
    if (state_q == ENG_WRITE && !found_q && !evict_q && free_q) used_d = used_q + CW'(1);
    if (state_q == ENG_IDLE && req_valid_i && req_i.kind == KIND_CLEAR) used_d = '0;
  end

  always_comb begin
    rsp_d = '0;
    rsp_d.occupancy = 7'(used_q);
    unique case (cur_q.kind)
      KIND_CLEAR: rsp_d.status = ST_CLEARED;
      KIND_READ: begin
        rsp_d.status = ST_READ;
        rsp_d.slot = cur_q.sel;
        if (32'(cur_q.sel) < TABLE_DEPTH && valid_q[AW'(cur_q.sel)]) begin
          rsp_d.entry_valid     = 1'b1;
          rsp_d.station_address = rd_q.station;
          rsp_d.last_dest       = rd_q.dest;
          rsp_d.last_heard      = rd_q.heard;
          rsp_d.beacon_time     = rd_q.btime;
          rsp_d.beacon_seen     = rd_q.bflag;
          rsp_d.heard_count     = rd_q.count;
        end
      end
      KIND_RECORD: begin
        rsp_d.status = st;
        rsp_d.slot = 6'(tgt_q);
        rsp_d.entry_valid     = 1'b1;
        rsp_d.station_address = wr_data.station;
        rsp_d.last_dest       = wr_data.dest;
        rsp_d.last_heard      = wr_data.heard;
        rsp_d.beacon_time     = wr_data.btime;
        rsp_d.beacon_seen     = wr_data.bflag;
        rsp_d.heard_count     = wr_data.count;
      end
      default: rsp_d.status = ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem_q[rd_addr];
    if (wr_en) mem_q[tgt_q] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (req_take_o) cur_q <= req_i;
    scan_i_q <= idx_q;
    if (state_q == ENG_LOOK) begin
      tgt_q   <= pick;
      evict_q <= evict;
    end
    if (state_q == ENG_SCAN && idx_q == '0) tgt_q <= '0;
    // Compare the slot whose data arrived this cycle.
    if (scan_v_q) begin
      if (valid_q[scan_i_q] && rd_q.station == cur_q.src && !found_q) hit_q <= scan_i_q;
      if (!valid_q[scan_i_q] && !free_q) fslot_q <= scan_i_q;
      if (valid_q[scan_i_q] && (!old_q || rd_q.heard < otime_q)) begin
        oslot_q <= scan_i_q;
        otime_q <= rd_q.heard;
      end
    end
    if (state_q == ENG_REPLY && (!rvalid_q || rsp_take_i)) rsp_q <= rsp_d;
  end

  // wr_data is a function of rd_q, which is stable through WRITE and REPLY.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ENG_IDLE;
      valid_q  <= '0;
      used_q   <= '0;
      idx_q    <= '0;
      scan_v_q <= 1'b0;
      found_q  <= 1'b0;
      free_q   <= 1'b0;
      old_q    <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      scan_v_q <= (state_q == ENG_SCAN);
      if (req_take_o) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
        old_q   <= 1'b0;
        if (req_i.kind == KIND_CLEAR) valid_q <= '0;
      end
      if (state_q == ENG_SCAN && idx_q != LAST) idx_q <= idx_q + AW'(1);
      if (scan_v_q) begin
        if (valid_q[scan_i_q] && rd_q.station == cur_q.src) found_q <= 1'b1;
        if (!valid_q[scan_i_q]) free_q <= 1'b1;
        if (valid_q[scan_i_q]) old_q <= 1'b1;
      end
      if (wr_en) valid_q[tgt_q] <= 1'b1;
      if (state_q == ENG_REPLY && (!rvalid_q || rsp_take_i)) rvalid_q <= 1'b1;
      else if (rsp_take_i) rvalid_q <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= TABLE_DEPTH)
    else $error("occupancy exceeds table depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == CW'($countones(valid_q)))
    else $error("occupancy disagrees with valid bits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == ENG_WRITE)
    else $error("table written outside write state");

endmodule
`default_nettype wire

### tb/heard_station_table_tb.sv
// Testbench for the heard station table: a scoreboard class predicts each result
// from its own copy of the table, plain tasks drive the APB port and the request queue,
// and an always block pops results. Depends on hst_pkg and heard_station_table.
`default_nettype none
module heard_station_table_tb import hst_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [1:0] ADDR_ACTIVE_LIMIT = 2'd0;

  typedef struct {
    kind_e       kind;
    logic [55:0] src;
    logic        src_ok;
    logic [55:0] dst;
    logic        ui;
    logic        info;
    logic [31:0] now;
    logic [5:0]  sel;
  } frame_t;

  class station_scoreboard;
    bit          used_slot[DEPTH];
    bit [55:0]   station[DEPTH];
    bit [55:0]   dest[DEPTH];
    bit [31:0]   heard[DEPTH];
    bit [31:0]   beacon_at[DEPTH];
    bit          beacon_flag[DEPTH];
    bit [31:0]   count[DEPTH];
    int unsigned occupied;
    int unsigned limit;
    rsp_t        waiting[$];
    int unsigned errors;

    function void reset_table();
      foreach (used_slot[i]) begin
        used_slot[i] = 0;
        station[i] = '0;
        dest[i] = '0;
        heard[i] = '0;
        beacon_at[i] = '0;
        beacon_flag[i] = 0;
        count[i] = '0;
      end
      occupied = 0;
      limit = 64;
      errors = 0;
    endfunction

    function rsp_t build(status_e st, int unsigned s, bit show);
      rsp_t r;
      r = '0;
      r.status = st;
      r.occupancy = occupied[6:0];
      if (show) begin
        r.slot = s[5:0];
        if (s < DEPTH && used_slot[s]) begin
          r.entry_valid = 1'b1;
          r.station_address = station[s];
          r.last_dest = dest[s];
          r.last_heard = heard[s];
          r.beacon_time = beacon_at[s];
          r.beacon_seen = beacon_flag[s];
          r.heard_count = count[s];
        end
      end
      return r;
    endfunction

    function rsp_t record(frame_t f);
      bit          beacon;
      int unsigned lim;
      int unsigned pick;
      bit          found;
      status_e     st;
      beacon = f.ui && f.info;
      found = 0;
      pick = 0;
      if (!f.src_ok) return build(ST_IGNORED, 0, 0);
      for (int unsigned i = 0; i < DEPTH; i++) begin
        if (used_slot[i] && station[i] == f.src) begin
          heard[i] = f.now;
          dest[i] = f.dst;
          if (count[i] != 32'hFFFF_FFFF) count[i]++;
          if (beacon) begin
            beacon_at[i] = f.now;
            beacon_flag[i] = 1;
          end
          return build(ST_UPDATED, i, 1);
        end
      end
      lim = limit;
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      if (occupied >= lim) begin
        // Oldest last-heard time goes; the strict compare keeps the lowest slot on a tie.
        for (int unsigned i = 0; i < DEPTH; i++) begin
          if (used_slot[i] && (!found || heard[i] < heard[pick])) begin
            pick = i;
            found = 1;
          end
        end
        st = ST_EVICTED;
      end else begin
        for (int unsigned i = 0; i < DEPTH; i++) begin
          if (!found && !used_slot[i]) begin
            pick = i;
            found = 1;
          end
        end
        occupied++;
        st = ST_INSERTED;
      end
      if (!found) return build(ST_IGNORED, 0, 0);
      used_slot[pick] = 1;
      station[pick] = f.src;
      dest[pick] = f.dst;
      heard[pick] = f.now;
      count[pick] = 1;
      beacon_flag[pick] = beacon;
      beacon_at[pick] = beacon ? f.now : 32'd0;
      return build(st, pick, 1);
    endfunction

    function void note_request(frame_t f);
      rsp_t r;
      case (f.kind)
        KIND_RECORD: r = record(f);
        KIND_CLEAR: begin
          foreach (used_slot[i]) used_slot[i] = 0;
          occupied = 0;
          r = build(ST_CLEARED, 0, 0);
        end
        KIND_READ: r = build(ST_READ, f.sel, 1);
        default: r = build(ST_IGNORED, 0, 0);
      endcase
      waiting.push_back(r);
    endfunction

    function bit field_ok(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        return 0;
      end
      return 1;
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      bit   ok;
      if (waiting.size() == 0) begin
        $display("%0t: result with no request waiting, status %0d", $time, a.status);
        errors++;
        return;
      end
      e = waiting.pop_front();
      ok = 1;
      ok &= field_ok("status", e.status, a.status);
      ok &= field_ok("slot", e.slot, a.slot);
      ok &= field_ok("entry_valid", e.entry_valid, a.entry_valid);
      ok &= field_ok("station_address", e.station_address, a.station_address);
      ok &= field_ok("last_dest", e.last_dest, a.last_dest);
      ok &= field_ok("last_heard", e.last_heard, a.last_heard);
      ok &= field_ok("beacon_time", e.beacon_time, a.beacon_time);
      ok &= field_ok("beacon_seen", e.beacon_seen, a.beacon_seen);
      ok &= field_ok("heard_count", e.heard_count, a.heard_count);
      ok &= field_ok("occupancy", e.occupancy, a.occupancy);
      if (!ok) errors++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push, full, empty, pop;
  logic [1:0]  kind_i;
  logic [55:0] source_address_i, dest_address_i;
  logic        source_valid_i, is_ui_frame_i, has_info_i;
  logic [31:0] now_seconds_i;
  logic [5:0]  slot_select_i;
  logic [2:0]  status_o;
  logic [5:0]  slot_o;
  logic        entry_valid_o, beacon_seen_o;
  logic [55:0] station_address_o, last_dest_o;
  logic [31:0] last_heard_o, beacon_time_o, heard_count_o;
  logic [6:0]  occupancy_o;

  heard_station_table DUT (.*);

  station_scoreboard sb;
  bit          calm;         // no idling on either side
  int unsigned cycles;
  int unsigned pop_gap;
  int unsigned requests_sent;
  bit [31:0]   clock_now;
  logic [55:0] pool[$];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random pop bursts, checked at the rising edge.
  always @(negedge clk_i) begin
    if (!calm && pop_gap == 0 && $urandom_range(0, 5) == 0) pop_gap = $urandom_range(1, 5);
    if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap--;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rsp_t a;
    if (rst_ni && pop && !empty) begin
      a.status = status_e'(status_o);
      a.slot = slot_o;
      a.entry_valid = entry_valid_o;
      a.station_address = station_address_o;
      a.last_dest = last_dest_o;
      a.last_heard = last_heard_o;
      a.beacon_time = beacon_time_o;
      a.beacon_seen = beacon_seen_o;
      a.heard_count = heard_count_o;
      a.occupancy = occupancy_o;
      sb.check_result(a);
    end
  end

  function automatic logic [55:0] rand56();
    return {$urandom(), $urandom()} & 64'h00FF_FFFF_FFFF_FFFF;
  endfunction

  task automatic drain();
    push <= 0;
    while (sb.waiting.size() != 0) @(posedge clk_i);
    // Let the engine finish before any register moves.
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [6:0] v);
    drain();
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_ACTIVE_LIMIT; pwdata <= {25'd0, v};
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    sb.limit = v;
    @(negedge clk_i);
    pwrite <= 0; penable <= 0;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    if (prdata[6:0] !== v) begin
      $display("%0t: active_limit readback, expected %0h, actual %0h", $time, v, prdata[6:0]);
      sb.errors++;
    end
    @(negedge clk_i);
    psel <= 0; penable <= 0;
  endtask

  // push stays high from one request to the next, but for random gaps; drain() drops it.
  task automatic send(frame_t f);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    push <= 1;
    kind_i <= f.kind;
    source_address_i <= f.src;
    source_valid_i <= f.src_ok;
    dest_address_i <= f.dst;
    is_ui_frame_i <= f.ui;
    has_info_i <= f.info;
    now_seconds_i <= f.now;
    slot_select_i <= f.sel;
    do @(posedge clk_i); while (full);
    sb.note_request(f);
    requests_sent++;
    @(negedge clk_i);
  endtask

  function automatic frame_t frame(kind_e k, logic [55:0] src, logic ok, logic [31:0] now,
                                   logic ui = 0, logic info = 0, logic [5:0] sel = 0);
    frame_t f;
    f.kind = k; f.src = src; f.src_ok = ok; f.dst = rand56();
    f.ui = ui; f.info = info; f.now = now; f.sel = sel;
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned r;
    f.src = rand56();
    f.dst = rand56();
    f.src_ok = ($urandom_range(0, 9) != 0);
    f.ui = $urandom_range(0, 1);
    f.info = $urandom_range(0, 1);
    f.sel = $urandom_range(0, 63);
    // Mostly slow-moving time so ties happen; now and then a jump anywhere.
    if ($urandom_range(0, 19) == 0) clock_now = $urandom();
    else clock_now += $urandom_range(0, 2);
    f.now = clock_now;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      f.kind = KIND_RECORD;
      if ($urandom_range(0, 4) != 0) f.src = pool[$urandom_range(0, pool.size() - 1)];
    end else if (r < 93) f.kind = KIND_READ;
    else if (r < 96) f.kind = KIND_CLEAR;
    else f.kind = KIND_NONE;
    return f;
  endfunction

  task automatic random_phase(logic [6:0] lim, int unsigned n);
    int unsigned span;
    set_limit(lim);
    span = (lim == 0) ? 1 : (lim > DEPTH ? DEPTH : lim);
    pool.delete();
    repeat (span + 4) pool.push_back(rand56());
    repeat (n) send(random_frame());
  endtask

  initial begin
    logic [55:0] ones;
    sb = new();
    sb.reset_table();
    ones = '1;
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    push = 0; pop = 0; kind_i = KIND_NONE; source_address_i = '0; source_valid_i = 0;
    dest_address_i = '0; is_ui_frame_i = 0; has_info_i = 0; now_seconds_i = '0;
    slot_select_i = '0; calm = 0; cycles = 0; pop_gap = 0; requests_sent = 0;
    clock_now = 32'd1000;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: extremes of addresses and time, beacons, update, ignored kinds, reads, a clear.
    send(frame(KIND_RECORD, '0, 1, 32'd0, 1, 1));
    send(frame(KIND_RECORD, ones, 1, 32'hFFFF_FFFF, 1, 0));
    send(frame(KIND_RECORD, ones, 1, 32'd5, 0, 1));
    send(frame(KIND_RECORD, ones, 1, 32'd6, 1, 1));
    send(frame(KIND_RECORD, 56'h12, 0, 32'd7));
    send(frame(KIND_READ, '0, 0, 32'd0, 0, 0, 6'd0));
    send(frame(KIND_READ, '0, 0, 32'd0, 0, 0, 6'd1));
    send(frame(KIND_READ, ones, 1, 32'd0, 1, 1, 6'd63));
    send(frame(KIND_NONE, ones, 1, 32'hFFFF_FFFF, 1, 1, 6'd63));
    send(frame(KIND_CLEAR, ones, 1, 32'd0));
    send(frame(KIND_READ, '0, 0, 32'd0, 0, 0, 6'd0));
    // Small limit: eviction, with a tie on the oldest time.
    set_limit(7'd2);
    send(frame(KIND_RECORD, 56'hA1, 1, 32'd50));
    send(frame(KIND_RECORD, 56'hA2, 1, 32'd50));
    send(frame(KIND_RECORD, 56'hA3, 1, 32'd60));
    send(frame(KIND_RECORD, 56'hA4, 1, 32'd70, 1, 1));
    // A limit of zero acts as one.
    set_limit(7'd0);
    send(frame(KIND_RECORD, 56'hB1, 1, 32'd80));
    send(frame(KIND_RECORD, 56'hB2, 1, 32'd90));
    // Fill past a lower limit, then lower it below occupancy.
    set_limit(7'd127);
    send(frame(KIND_RECORD, 56'hC1, 1, 32'd3));
    send(frame(KIND_RECORD, 56'hC2, 1, 32'd2));
    send(frame(KIND_RECORD, 56'hC3, 1, 32'd4));
    set_limit(7'd1);
    send(frame(KIND_RECORD, 56'hC4, 1, 32'd9));
    send(frame(KIND_READ, '0, 0, 32'd0, 0, 0, 6'd3));

    random_phase(7'd64, 220);
    random_phase(7'd1, 120);
    random_phase(7'd3, 200);
    // Hold the sender until the block has answered everything.
    drain();
    random_phase(7'd8, 200);
    random_phase(7'd127, 220);
    random_phase(7'd0, 100);
    random_phase(7'($urandom_range(1, 64)), 200);
    calm = 1;
    random_phase(7'd16, 200);
    random_phase(7'd64, 150);

    push <= 0;
    while (sb.waiting.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d requests over limits 0, 1, 2, 3, 8, 16, 64, 127 and one random,",
             requests_sent);
    $display("with inserts, updates, evictions, reads, clears and ignored kinds");
    if (sb.errors == 0 && sb.waiting.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
